[src/triangle_overlap_test_core_assert.svh]
// Assertion macros shared by the triangle overlap test RTL
`ifndef TRIANGLE_OVERLAP_TEST_CORE_ASSERT_SVH
`define TRIANGLE_OVERLAP_TEST_CORE_ASSERT_SVH
// Implication checked on every clock edge outside reset
`define TOT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset
`define TOT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[src/tot_pkg.sv]
// Package: widths, types and the vector subtract helper of the triangle overlap test
`timescale 1ns / 1ps
`default_nettype none
package tot_pkg;
    localparam int COORD_WIDTH = 16;
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int PROD_WIDTH  = 2 * DIFF_WIDTH;
    localparam int CROSS_WIDTH = PROD_WIDTH + 1;
    localparam int TDATA_WIDTH = ((12 * COORD_WIDTH + 7) / 8) * 8;
    localparam int NUM_CROSS   = 9;
    localparam int NUM_INSIDE  = 18;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;
    typedef logic signed [DIFF_WIDTH-1:0]  diff_t;
    typedef logic signed [PROD_WIDTH-1:0]  prod_t;
    typedef logic signed [CROSS_WIDTH-1:0] cross_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
    } vec_t;

    function automatic vec_t vsub(input point_t a, input point_t b);
        vec_t r;
        r.x = DIFF_WIDTH'(a.x) - DIFF_WIDTH'(b.x);
        r.y = DIFF_WIDTH'(a.y) - DIFF_WIDTH'(b.y);
        return r;
    endfunction
endpackage
`default_nettype wire

[src/triangle_overlap_test_core.sv]
// Top level: pipelined 2-D triangle pair overlap test
//
// Slave channel s_axis_*: one transfer carries both triangles, twelve signed
// coordinates packed in tdata. Master channel m_axis_*: one transfer per input
// carrying the overlap flag in tdata bit 0.
// Pipeline: S0 edge vectors, S1 products, S2 cross products, S3 per-test
// decisions, S4 final OR into the output register. The flag is valid once the
// input transfer has passed through S0 to S4; throughput is one transfer per
// cycle while the receiver does not stall, set by the fully pipelined array
// of 63 cross product units.
// The whole pipeline advances together whenever the output register is empty
// or being taken; when the receiver stalls, every stage holds and
// s_axis_tready drops, so nothing is lost or repeated.
// Reset clears all valid bits; payload registers are left as they are.
`timescale 1ns / 1ps
`default_nettype none
`include "triangle_overlap_test_core_assert.svh"
module triangle_overlap_test_core
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // first_a_x, first_a_y, first_b_x, first_b_y, first_c_x, first_c_y,
    // second_a_x, second_a_y, second_b_x, second_b_y, second_c_x, second_c_y
    input  wire logic [tot_pkg::TDATA_WIDTH-1:0] s_axis_tdata,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // overlap, zero padding
    output logic [7:0]                           m_axis_tdata
);
    import tot_pkg::*;

    localparam int NSTG = 5;

    logic            adv;
    logic [NSTG-1:0] vld_reg;
    logic [NSTG-1:0] vld_next;

    // advance whole pipeline unless output is held
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NSTG-1];

    always_comb
    begin
        vld_next = {vld_reg[NSTG-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= vld_next;
    end

    // unpack input
    point_t pt [6];
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            pt[i].x = s_axis_tdata[(2*i)*COORD_WIDTH +: COORD_WIDTH];
            pt[i].y = s_axis_tdata[(2*i+1)*COORD_WIDTH +: COORD_WIDTH];
        end
    end

    // S0: register edge vectors for each cross product
    // edge tests: den=d1xd2, n1=d1xw, n2=d2xw (27 units)
    // inside tests: 18 same-side checks, two products each (36 units)
    localparam int NCU = 3 * NUM_CROSS + 2 * NUM_INSIDE;
    vec_t u_reg [NCU];
    vec_t v_reg [NCU];
    vec_t u_next [NCU];
    vec_t v_next [NCU];
    logic same_reg;

    always_comb
    begin
        int e1a [3];
        int e1b [3];
        int e2a [3];
        int e2b [3];
        int k;
        int p;
        int q1;
        int q2;
        int tb;
        vec_t d1;
        vec_t d2;
        vec_t w;
        vec_t e;
        e1a = '{0, 1, 2};
        e1b = '{1, 2, 0};
        e2a = '{3, 3, 4};
        e2b = '{4, 5, 5};
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                k  = 3 * (3 * i + j);
                d1 = vsub(pt[e1b[i]], pt[e1a[i]]);
                d2 = vsub(pt[e2b[j]], pt[e2a[j]]);
                w  = vsub(pt[e1a[i]], pt[e2a[j]]);
                u_next[k]   = d1;
                v_next[k]   = d2;
                u_next[k+1] = d1;
                v_next[k+1] = w;
                u_next[k+2] = d2;
                v_next[k+2] = w;
            end
        end
        // same_side(p, other, q1, q2) with vertex sets
        for (int t = 0; t < NUM_INSIDE; t++)
        begin
            // t = 3*pidx + side; pidx 0..5 chooses the tested point
            p  = t / 3;
            tb = (p < 3) ? 3 : 0;
            unique case (t % 3)
                0: begin q1 = tb + 1; q2 = tb + 2; end
                1: begin q1 = tb;     q2 = tb + 2; end
                default: begin q1 = tb; q2 = tb + 1; end
            endcase
            e = vsub(pt[q2], pt[q1]);
            u_next[3*NUM_CROSS + 2*t]     = e;
            u_next[3*NUM_CROSS + 2*t + 1] = e;
            v_next[3*NUM_CROSS + 2*t]     = vsub(pt[p], pt[q1]);
            v_next[3*NUM_CROSS + 2*t + 1] = vsub(pt[tb + t % 3], pt[q1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < NCU; i++)
            begin
                u_reg[i] <= u_next[i];
                v_reg[i] <= v_next[i];
            end
            same_reg <= (pt[0] == pt[3]) && (pt[1] == pt[4]) && (pt[2] == pt[5]);
        end
    end

    // S1, S2: cross products
    cross_t cr [NCU];
    logic   same_d1_reg;
    logic   same_d2_reg;
    for (genvar g = 0; g < NCU; g++)
    begin : g_cu
        tot_cross_unit u_cu
        (
            .clk   (clk),
            .en    (adv),
            .u     (u_reg[g]),
            .v     (v_reg[g]),
            .xprod (cr[g])
        );
    end

    // S3: per-test decisions
    logic [NUM_CROSS-1:0]  xhit_reg;
    logic [NUM_INSIDE-1:0] side_reg;
    logic                  same_d3_reg;

    function automatic logic open_unit(input cross_t num, input cross_t den);
        cross_t an;
        cross_t ad;
        an = num[CROSS_WIDTH-1] ? -num : num;
        ad = den[CROSS_WIDTH-1] ? -den : den;
        return (num != '0) && (num[CROSS_WIDTH-1] == den[CROSS_WIDTH-1]) && (an < ad);
    endfunction

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            same_d1_reg <= same_reg;
            same_d2_reg <= same_d1_reg;
            same_d3_reg <= same_d2_reg;
            for (int i = 0; i < NUM_CROSS; i++)
                xhit_reg[i] <= (cr[3*i] != '0) && open_unit(cr[3*i+1], cr[3*i])
                               && open_unit(cr[3*i+2], cr[3*i]);
            for (int t = 0; t < NUM_INSIDE; t++)
                side_reg[t] <= (cr[3*NUM_CROSS+2*t] == '0)
                               || (cr[3*NUM_CROSS+2*t+1] == '0)
                               || (cr[3*NUM_CROSS+2*t][CROSS_WIDTH-1]
                                   == cr[3*NUM_CROSS+2*t+1][CROSS_WIDTH-1]);
        end
    end

    // S4: combine into output register
    logic ovl_reg;
    logic ovl_next;
    always_comb
    begin
        ovl_next = same_d3_reg || (|xhit_reg);
        for (int p = 0; p < 6; p++)
            ovl_next = ovl_next || (side_reg[3*p] && side_reg[3*p+1] && side_reg[3*p+2]);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            ovl_reg <= ovl_next;
    end

    assign m_axis_tdata = {7'b0, ovl_reg};

    `TOT_ASSERT_IMP(a_ready_adv, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        !s_axis_tready, "input accepted while output stalled")
    `TOT_ASSERT_NXT(a_enter, clk, rst_n, s_axis_tvalid && s_axis_tready,
        vld_reg[0], "accepted transfer did not enter pipeline")
    `TOT_ASSERT_NXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(vld_reg), "pipeline moved during stall")
endmodule
`default_nettype wire

[src/tot_cross_unit.sv]
// Registered 2-D cross product: one multiplier stage, one subtract stage
`timescale 1ns / 1ps
`default_nettype none
module tot_cross_unit
(
    input  wire logic          clk,
    input  wire logic          en,
    input  wire tot_pkg::vec_t u,
    input  wire tot_pkg::vec_t v,
    output tot_pkg::cross_t    xprod
);
    import tot_pkg::*;

    prod_t  p0_reg;
    prod_t  p1_reg;
    cross_t cross_reg;

    // payload only; enable follows the pipeline advance
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg    <= u.x * v.y;
            p1_reg    <= u.y * v.x;
            cross_reg <= CROSS_WIDTH'(p0_reg) - CROSS_WIDTH'(p1_reg);
        end
    end

    assign xprod = cross_reg;
endmodule
`default_nettype wire

[tb/tb_triangle_overlap_test_core.sv]
// Testbench for the triangle pair overlap test core
`timescale 1ns / 1ps
module tb_triangle_overlap_test_core;
    import tot_pkg::*;

    localparam int NUM_RANDOM   = 1800;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 20;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // first_a_x, first_a_y, first_b_x, first_b_y, first_c_x, first_c_y,
    // second_a_x, second_a_y, second_b_x, second_b_y, second_c_x, second_c_y
    logic [TDATA_WIDTH-1:0] s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // overlap, zero padding
    logic [7:0]             m_axis_tdata;

    // One triangle pair: vertex k of the first is 0..2, of the second 3..5
    typedef struct {
        coord_t x[6];
        coord_t y[6];
    } tri_pair_t;

    tri_pair_t pending_pairs[$];
    bit        expected_overlap[$];
    int        error_count;
    bit        stim_done;
    bit        hold_sender;
    int        send_gap;
    int        take_gap;
    int        idle_cycles;

    triangle_overlap_test_core DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // ---------------------------------------------------------------
    // Exact predictor. Coordinates are 16 bits, so differences fit in
    // 17 bits, products in 34 and cross products comfortably in 64.
    // ---------------------------------------------------------------
    function automatic longint orient(longint ux, longint uy, longint vx, longint vy);
        return ux * vy - uy * vx;
    endfunction

    // num/den strictly inside (0,1)
    function automatic bit strictly_between(longint num, longint den);
        longint an;
        longint ad;
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        if (num == 0 || ((num < 0) != (den < 0)))
            return 1'b0;
        return an < ad;
    endfunction

    function automatic bit edges_cross(tri_pair_t t, int p0, int p1, int p2, int p3);
        longint d1x;
        longint d1y;
        longint d2x;
        longint d2y;
        longint wx;
        longint wy;
        longint den;
        d1x = longint'(t.x[p1]) - longint'(t.x[p0]);
        d1y = longint'(t.y[p1]) - longint'(t.y[p0]);
        d2x = longint'(t.x[p3]) - longint'(t.x[p2]);
        d2y = longint'(t.y[p3]) - longint'(t.y[p2]);
        wx  = longint'(t.x[p0]) - longint'(t.x[p2]);
        wy  = longint'(t.y[p0]) - longint'(t.y[p2]);
        den = orient(d1x, d1y, d2x, d2y);
        // parallel or collinear edges never cross
        if (den == 0)
            return 1'b0;
        return strictly_between(orient(d1x, d1y, wx, wy), den)
            && strictly_between(orient(d2x, d2y, wx, wy), den);
    endfunction

    // p and r on the same side of line q1-q2; on the line counts as same side
    function automatic bit on_same_side(tri_pair_t t, int p, int r, int q1, int q2);
        longint ex;
        longint ey;
        longint c1;
        longint c2;
        ex = longint'(t.x[q2]) - longint'(t.x[q1]);
        ey = longint'(t.y[q2]) - longint'(t.y[q1]);
        c1 = orient(ex, ey, longint'(t.x[p]) - t.x[q1], longint'(t.y[p]) - t.y[q1]);
        c2 = orient(ex, ey, longint'(t.x[r]) - t.x[q1], longint'(t.y[r]) - t.y[q1]);
        if (c1 == 0 || c2 == 0)
            return 1'b1;
        return (c1 < 0) == (c2 < 0);
    endfunction

    function automatic bit point_in_tri(tri_pair_t t, int p, int a, int b, int c);
        return on_same_side(t, p, a, b, c) && on_same_side(t, p, b, a, c)
            && on_same_side(t, p, c, a, b);
    endfunction

    function automatic bit predict_overlap(tri_pair_t t);
        int first_edge[3][2];
        int second_edge[3][2];
        bit same;
        first_edge  = '{'{0, 1}, '{1, 2}, '{2, 0}};
        second_edge = '{'{3, 4}, '{3, 5}, '{4, 5}};
        same = 1'b1;
        for (int i = 0; i < 3; i++)
            if (t.x[i] != t.x[i+3] || t.y[i] != t.y[i+3])
                same = 1'b0;
        if (same)
            return 1'b1;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                if (edges_cross(t, first_edge[i][0], first_edge[i][1],
                                second_edge[j][0], second_edge[j][1]))
                    return 1'b1;
        for (int i = 0; i < 3; i++)
            if (point_in_tri(t, i, 3, 4, 5))
                return 1'b1;
        for (int i = 3; i < 6; i++)
            if (point_in_tri(t, i, 0, 1, 2))
                return 1'b1;
        return 1'b0;
    endfunction

    // Pack x,y of vertex 0 first, lowest bits up
    function automatic logic [TDATA_WIDTH-1:0] pack_pair(tri_pair_t t);
        logic [TDATA_WIDTH-1:0] d;
        d = '0;
        for (int k = 0; k < 6; k++)
        begin
            d[(2*k)*COORD_WIDTH +: COORD_WIDTH]   = t.x[k];
            d[(2*k+1)*COORD_WIDTH +: COORD_WIDTH] = t.y[k];
        end
        return d;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Random coordinate: full range, a small box to force contacts, or an extreme
    function automatic coord_t rand_coord(int style);
        case (style)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 16)) - 8);
            default:
                case ($urandom_range(0, 3))
                    0: return 16'sh7FFF;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    default: return 16'shFFFF;
                endcase
        endcase
    endfunction

    task automatic push_pair(tri_pair_t t);
        pending_pairs.push_back(t);
    endtask

    task automatic push_coords(int c[12]);
        tri_pair_t t;
        for (int k = 0; k < 6; k++)
        begin
            t.x[k] = coord_t'(c[2*k]);
            t.y[k] = coord_t'(c[2*k+1]);
        end
        push_pair(t);
    endtask

    // ---------------------------------------------------------------
    // Stimulus: directed corners, then random pairs
    // ---------------------------------------------------------------
    initial
    begin
        tri_pair_t t;
        int style;
        stim_done   = 1'b0;
        hold_sender = 1'b0;
        // identical triangles
        push_coords('{0, 0, 10, 0, 0, 10, 0, 0, 10, 0, 0, 10});
        // same vertices in another order
        push_coords('{0, 0, 10, 0, 0, 10, 10, 0, 0, 10, 0, 0});
        // disjoint
        push_coords('{0, 0, 4, 0, 0, 4, 10, 10, 14, 10, 10, 14});
        // star of David: edges cross strictly
        push_coords('{0, 0, 12, 0, 6, 10, 0, 7, 12, 7, 6, -3});
        // second fully inside first
        push_coords('{-100, -100, 100, -100, 0, 100, -1, 0, 1, 0, 0, 1});
        // first fully inside second
        push_coords('{-1, 0, 1, 0, 0, 1, -100, -100, 100, -100, 0, 100});
        // vertex touches a vertex
        push_coords('{0, 0, 4, 0, 0, 4, 4, 0, 8, 0, 8, 4});
        // vertex on an edge of the other
        push_coords('{0, 0, 4, 0, 0, 4, 2, 2, 6, 2, 6, 6});
        // collinear overlapping edges, each with a vertex on an edge of the other
        push_coords('{0, 0, 10, 0, 5, -5, 5, 0, 15, 0, 10, 5});
        // parallel edges close by
        push_coords('{0, 0, 10, 0, 5, 5, 0, -1, 10, -1, 5, -6});
        // degenerate: all points of each triangle equal
        push_coords('{3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3, 3});
        push_coords('{3, 3, 3, 3, 3, 3, 5, 5, 5, 5, 5, 5});
        // degenerate segment crossing a segment
        push_coords('{-5, 0, 5, 0, 5, 0, 0, -5, 0, 5, 0, 5});
        // extremes of the coordinate range
        push_coords('{-32768, -32768, 32767, -32768, -32768, 32767,
                      32767, 32767, -32768, 32767, 32767, -32768});
        push_coords('{-32768, -32768, 32767, -32768, -32768, 32767,
                      -32768, -32768, 32767, -32768, -32768, 32767});
        push_coords('{32767, 32767, 32767, 32767, 32767, 32767,
                      -32768, -32768, -32768, -32768, -32768, -32768});
        push_coords('{-1, -1, -1, -1, -1, -1, 0, 0, 0, 0, 0, 0});
        push_coords('{-32768, 0, 32767, 0, 0, 32767, 0, -32768, 0, 32767, 32767, 32767});
        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            style = $urandom_range(0, 9);
            for (int k = 0; k < 6; k++)
            begin
                // mix: small box gives many contacts and degenerate cases
                if (style < 4)
                    t.x[k] = rand_coord(0);
                else if (style < 9)
                    t.x[k] = rand_coord(1);
                else
                    t.x[k] = rand_coord($urandom_range(0, 2));
                if (style < 4)
                    t.y[k] = rand_coord(0);
                else if (style < 9)
                    t.y[k] = rand_coord(1);
                else
                    t.y[k] = rand_coord($urandom_range(0, 2));
            end
            // now and then copy the first triangle, perhaps nudged
            if ($urandom_range(0, 19) == 0)
                for (int k = 0; k < 3; k++)
                begin
                    t.x[k+3] = t.x[k];
                    t.y[k+3] = t.y[k] + coord_t'($urandom_range(0, 1));
                end
            push_pair(t);
            // once, midway, hold the sender until the pipe drains
            if (n == NUM_RANDOM / 2)
            begin
                wait (pending_pairs.size() == 0);
                hold_sender = 1'b1;
                wait (expected_overlap.size() == 0);
                hold_sender = 1'b0;
            end
        end
        stim_done = 1'b1;
    end

    // ---------------------------------------------------------------
    // Driver
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            send_gap      <= 0;
        end
        else
        begin
            // a transfer just completed: record its expected flag
            if (s_axis_tvalid && s_axis_tready)
                expected_overlap.push_back(predict_overlap(pending_pairs.pop_front()));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (send_gap > 0)
                begin
                    s_axis_tvalid <= 1'b0;
                    send_gap      <= send_gap - 1;
                end
                else if (pending_pairs.size() > (s_axis_tvalid && s_axis_tready ? 0 : 0)
                         && !hold_sender)
                begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pack_pair(pending_pairs[0]);
                    send_gap      <= pick_gap();
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor with random back-pressure
    // ---------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            take_gap      <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_overlap.size() == 0)
                begin
                    $display("%0t: unexpected transfer, actual overlap %0b",
                             $time, m_axis_tdata[0]);
                    error_count++;
                end
                else if (m_axis_tdata[0] !== expected_overlap[0])
                begin
                    $display("%0t: overlap mismatch, expected %0b actual %0b",
                             $time, expected_overlap[0], m_axis_tdata[0]);
                    error_count++;
                    void'(expected_overlap.pop_front());
                end
                else
                    void'(expected_overlap.pop_front());
            end
            if (take_gap > 0)
            begin
                m_axis_tready <= 1'b0;
                take_gap      <= take_gap - 1;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                take_gap      <= pick_gap();
            end
        end
    end

    // Watchdog: count cycles without any transfer
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idle_cycles <= 0;
        else if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    // ---------------------------------------------------------------
    // Reset, end of run
    // ---------------------------------------------------------------
    initial
    begin
        error_count = 0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        fork
            begin
                wait (stim_done && pending_pairs.size() == 0 && !s_axis_tvalid
                      && expected_overlap.size() == 0);
                repeat (DRAIN_CYCLES) @(posedge clk);
                if (error_count == 0 && expected_overlap.size() == 0)
                    $display("Simulation PASSED");
                else
                    $display("Simulation FAILED");
                $finish;
            end
            begin
                wait (idle_cycles >= STALL_LIMIT);
                $display("%0t: watchdog expired", $time);
                $display("Simulation FAILED");
                $finish;
            end
        join
    end
endmodule
